[rtl/wsdt_pkg.sv]
package wsdt_pkg;

    // table and field sizes
    localparam int DEPTH       = 256;
    localparam int AW          = 8;
    localparam int NW          = 9;
    localparam int VW          = 20;
    localparam int CW          = 24;
    localparam int WW          = 16;
    localparam int PW          = 17;
    localparam int SW          = 44;
    localparam int SQW         = 64;
    localparam int KW          = 2;
    localparam int STW         = 3;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 152;
    localparam int OUT_USED_W  = 150;

    // wide operand sizes of the shared arithmetic unit
    localparam int AXW = 128;
    localparam int BXW = 64;
    localparam int CNTW = 7;

    localparam logic [NW-1:0]        DEPTH_N = NW'(DEPTH);
    localparam logic [PW-1:0]        ONE_Q16 = 17'h10000;
    localparam logic [CW-1:0]        CMAX    = '1;
    localparam logic signed [VW-1:0] VMAX    = 20'sh7FFFF;
    localparam logic signed [VW-1:0] VMIN    = 20'sh80000;
    localparam logic [VW-1:0]        VMASK   = '1;

    typedef enum logic [KW-1:0] {
        K_ADD   = 2'd0,
        K_QUANT = 2'd1,
        K_CDF   = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [STW-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_PROB  = 3'd2,
        ST_FULL  = 3'd3,
        ST_SAT   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ADD_CHK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_INS_WR,
        S_SQ_ACC,
        S_STD_M1,
        S_STD_M2,
        S_STD_CMP,
        S_STD_DIV,
        S_STD_SQRT,
        S_MEAN_DIV,
        S_Q_MUL,
        S_Q_RD,
        S_Q_CMP,
        S_Q_LAST_RD,
        S_Q_LAST_CAP,
        S_C_RD,
        S_C_CMP,
        S_C_M1,
        S_C_M2,
        S_C_M3,
        S_C_DIV,
        S_DONE
    } t_state;

endpackage

[rtl/wsdt_alu.sv]
module wsdt_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wsdt_pkg::t_alu_req            i_req,
    input  logic [wsdt_pkg::AXW-1:0]      i_a,
    input  logic [wsdt_pkg::BXW-1:0]      i_b,
    output wsdt_pkg::t_alu_rsp            o_rsp,
    output logic [wsdt_pkg::AXW-1:0]      o_res,
    output logic [wsdt_pkg::BXW-1:0]      o_rem
);
    import wsdt_pkg::*;

    logic            r_run, n_run;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    t_alu_op         r_op, n_op;
    logic [AXW-1:0]  r_x, n_x;
    logic [AXW-1:0]  r_y, n_y;
    logic [BXW-1:0]  r_z, n_z;
    logic [BXW-1:0]  r_rem, n_rem;

    logic [BXW:0]    div_t;
    logic [BXW:0]    div_d;
    logic            div_ge;
    logic [BXW-1:0]  sq_sum;

    // helpers for one step of the divide and the square root
    always_comb begin
        div_t  = {r_rem, r_x[AXW-1]};
        div_d  = {1'b0, r_z};
        div_ge = (div_t >= div_d);
        sq_sum = r_y[BXW-1:0] + r_z;
    end

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_rem  = r_rem;
        if (i_req.start && !r_run) begin
            n_run = 1'b1;
            n_op  = i_req.op;
            case (i_req.op)
                ALU_MUL: begin
                    n_x   = '0;
                    n_y   = i_a;
                    n_z   = i_b;
                    n_cnt = CNTW'(BXW - 1);
                end
                ALU_DIV: begin
                    n_x   = i_a;
                    n_z   = i_b;
                    n_rem = '0;
                    n_cnt = CNTW'(AXW - 1);
                end
                ALU_SQRT: begin
                    n_x   = {{(AXW-BXW){1'b0}}, i_a[BXW-1:0]};
                    n_y   = '0;
                    n_z   = {2'b01, {(BXW-2){1'b0}}};
                    n_cnt = CNTW'(BXW/2 - 1);
                end
                default: begin
                    n_run = 1'b0;
                end
            endcase
        end else if (r_run) begin
            case (r_op)
                // shift-add multiply, multiplier bits from the low end
                ALU_MUL: begin
                    n_x = r_z[0] ? (r_x + r_y) : r_x;
                    n_y = {r_y[AXW-2:0], 1'b0};
                    n_z = {1'b0, r_z[BXW-1:1]};
                end
                // restoring divide, quotient bits shift in at the bottom
                ALU_DIV: begin
                    n_rem = div_ge ? BXW'(div_t - div_d) : div_t[BXW-1:0];
                    n_x   = {r_x[AXW-2:0], div_ge};
                end
                // digit-by-digit square root
                ALU_SQRT: begin
                    if (r_x[BXW-1:0] >= sq_sum) begin
                        n_x = {{(AXW-BXW){1'b0}}, r_x[BXW-1:0] - sq_sum};
                        n_y = {{(AXW-BXW){1'b0}}, ({1'b0, r_y[BXW-1:1]} + r_z)};
                    end else begin
                        n_y = {{(AXW-BXW){1'b0}}, 1'b0, r_y[BXW-1:1]};
                    end
                    n_z = {2'b00, r_z[BXW-1:2]};
                end
                default: begin
                    n_x = r_x;
                end
            endcase
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_res      = (r_op == ALU_SQRT) ? r_y : r_x;
    assign o_rem      = r_rem;

endmodule

[rtl/weighted_sorted_distribution_table_top.sv]
// operation: add searches the table and shifts entries, then updates the statistics
// on the shared arithmetic unit (up to two 64-step multiplies, two 128-step divides
// and a 32-step square root).
// throughput: one request at a time, set by the shared iterative arithmetic unit and
// the sorted table; a finished result waits in an output register.
// reset: synchronous active low clears counts, sums, min/max and the sequencer; table
// contents are not cleared, only entries below the entry count are ever read.
module weighted_sorted_distribution_table_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // sample[19:0], weight[35:20], prob_in[52:36], zero pad
    input  logic [wsdt_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // kind[1:0]
    input  logic [wsdt_pkg::KW-1:0]               i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // value_out[19:0], prob_out[36:20], mean_out[56:37], std_dev[76:57],
    // total_count[100:77], min_out[120:101], max_out[140:121],
    // entries_used[149:141], zero pad
    output logic [wsdt_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // status[2:0]
    output logic [wsdt_pkg::STW-1:0]              o_m_tuser
);
    import wsdt_pkg::*;

    // architectural state
    t_state                r_state, n_state;
    logic [NW-1:0]         r_n, n_n;
    logic [CW-1:0]         r_count, n_count;
    logic signed [SW-1:0]  r_sum, n_sum;
    logic [SQW-1:0]        r_sqsum, n_sqsum;
    logic signed [VW-1:0]  r_min, n_min;
    logic signed [VW-1:0]  r_max, n_max;
    logic [VW-1:0]         r_mean, n_mean;
    logic [VW-1:0]         r_std, n_std;
    logic                  r_o_valid, n_o_valid;
    logic                  r_alu_busy, n_alu_busy;

    // working registers
    logic signed [VW-1:0]  r_s, n_s;
    logic [WW-1:0]         r_w, n_w;
    logic [PW-1:0]         r_p, n_p;
    logic [NW-1:0]         r_idx, n_idx;
    logic [NW-1:0]         r_pos, n_pos;
    logic                  r_equal, n_equal;
    logic signed [VW-1:0]  r_prev_val, n_prev_val;
    logic [CW-1:0]         r_prev_cum, n_prev_cum;
    logic [2*VW-1:0]       r_sq_tmp, n_sq_tmp;
    logic [AXW-1:0]        r_t1, n_t1;
    logic [AXW-1:0]        r_t2, n_t2;
    logic [VW:0]           r_span, n_span;
    logic [CW-1:0]         r_dc, n_dc;
    logic [CW-1:0]         r_target, n_target;
    t_status               r_res_status, n_res_status;
    logic [VW-1:0]         r_res_val, n_res_val;
    logic [PW-1:0]         r_res_prob, n_res_prob;
    logic [OUT_TDATA_W-1:0] r_o_data, n_o_data;
    t_status               r_o_status, n_o_status;

    // table memory
    logic signed [VW-1:0]  m_val [DEPTH];
    logic [CW-1:0]         m_cum [DEPTH];
    logic signed [VW-1:0]  r_rd_val;
    logic [CW-1:0]         r_rd_cum;
    logic                  mem_re, mem_we;
    logic [AW-1:0]         mem_ra, mem_wa;
    logic signed [VW-1:0]  mem_wv;
    logic [CW-1:0]         mem_wc;

    // arithmetic unit
    t_alu_req              alu_req;
    t_alu_rsp              alu_rsp;
    logic [AXW-1:0]        alu_a;
    logic [BXW-1:0]        alu_b;
    logic [AXW-1:0]        alu_res;
    logic [BXW-1:0]        alu_rem;
    logic                  alu_state;

    // request fields
    logic                  in_fire;
    t_kind                 in_kind;
    logic signed [VW-1:0]  in_s;
    logic [WW-1:0]         in_w;
    logic [PW-1:0]         in_p;

    // helpers
    logic [SW-1:0]         sum_mag;
    logic                  add_full;
    logic                  add_sat;
    logic [NW-1:0]         idx_dec;
    logic [NW-1:0]         n_dec;
    logic                  cdf_go_on;
    logic [2*CW-1:0]       cnt_pair;
    logic [VW+WW:0]        sw_prod;
    logic [2*VW+WW-1:0]    sq_prod;
    logic [PW+CW-1:0]      tgt_prod;
    logic [VW:0]           d_off;
    logic [VW:0]           v1_off;
    logic [CW+VW:0]        cm_prod;
    logic [VW-1:0]         mean_q;

    assign in_fire = i_s_tvalid && o_s_tready;
    assign in_kind = t_kind'(i_s_tuser);
    assign in_s    = i_s_tdata[VW-1:0];
    assign in_w    = i_s_tdata[VW+WW-1:VW];
    assign in_p    = i_s_tdata[VW+WW+PW-1:VW+WW];

    always_comb begin
        sum_mag   = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        add_full  = !r_equal && (r_n == DEPTH_N);
        add_sat   = ({1'b0, r_count} + {{(CW+1-WW){1'b0}}, r_w}) > {1'b0, CMAX};
        idx_dec   = r_idx - NW'(1);
        n_dec     = r_n - NW'(1);
        cdf_go_on = (r_idx == '0) || (((r_idx + NW'(1)) < r_n) && (r_rd_val < r_s));
        cnt_pair  = r_count * (r_count - CW'(1));
        sw_prod   = (VW+WW+1)'($signed({r_s[VW-1], r_s}) * $signed({1'b0, r_w}));
        sq_prod   = r_sq_tmp * r_w;
        tgt_prod  = r_p * r_count;
        d_off     = {r_s[VW-1], r_s} - {r_prev_val[VW-1], r_prev_val};
        v1_off    = {r_rd_val[VW-1], r_rd_val} - {r_prev_val[VW-1], r_prev_val};
        cm_prod   = (CW+VW+1)'(r_prev_cum * r_span);
        mean_q    = alu_res[VW-1:0];
        alu_state = r_state inside {S_STD_M1, S_STD_M2, S_STD_DIV, S_STD_SQRT,
                                    S_MEAN_DIV, S_C_DIV};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (in_kind)
                        K_ADD: begin
                            n_state = (in_w == '0) ? S_DONE : S_SCAN_RD;
                        end
                        K_QUANT: begin
                            if ((r_n == '0) || (in_p > ONE_Q16)) begin
                                n_state = S_DONE;
                            end else if (in_p == ONE_Q16) begin
                                n_state = S_Q_LAST_RD;
                            end else begin
                                n_state = S_Q_MUL;
                            end
                        end
                        K_CDF: begin
                            if ((r_n == '0) || (r_count == '0) || (in_s < r_min)
                                || (in_s >= r_max)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_C_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:   n_state = (r_idx == r_n) ? S_ADD_CHK : S_SCAN_CMP;
            S_SCAN_CMP:  n_state = (r_rd_val < r_s) ? S_SCAN_RD : S_ADD_CHK;
            S_ADD_CHK:   n_state = (add_full || add_sat) ? S_DONE : S_MOVE_RD;
            S_MOVE_RD:   n_state = (!r_equal && (r_idx == r_pos)) ? S_INS_WR : S_MOVE_WR;
            S_MOVE_WR:   n_state = (r_equal && (r_idx == r_pos)) ? S_SQ_ACC : S_MOVE_RD;
            S_INS_WR:    n_state = S_SQ_ACC;
            S_SQ_ACC:    n_state = (r_count <= CW'(1)) ? S_MEAN_DIV : S_STD_M1;
            S_STD_M1:    n_state = alu_rsp.done ? S_STD_M2 : S_STD_M1;
            S_STD_M2:    n_state = alu_rsp.done ? S_STD_CMP : S_STD_M2;
            S_STD_CMP:   n_state = (r_t1 <= r_t2) ? S_MEAN_DIV : S_STD_DIV;
            S_STD_DIV:   n_state = alu_rsp.done ? S_STD_SQRT : S_STD_DIV;
            S_STD_SQRT:  n_state = alu_rsp.done ? S_MEAN_DIV : S_STD_SQRT;
            S_MEAN_DIV:  n_state = alu_rsp.done ? S_DONE : S_MEAN_DIV;
            S_Q_MUL:     n_state = S_Q_RD;
            S_Q_RD:      n_state = (r_idx == r_n) ? S_Q_LAST_RD : S_Q_CMP;
            S_Q_CMP:     n_state = (r_rd_cum > r_target) ? S_DONE : S_Q_RD;
            S_Q_LAST_RD: n_state = S_Q_LAST_CAP;
            S_Q_LAST_CAP: n_state = S_DONE;
            S_C_RD:      n_state = S_C_CMP;
            S_C_CMP:     n_state = cdf_go_on ? S_C_RD : S_C_M1;
            S_C_M1:      n_state = S_C_M2;
            S_C_M2:      n_state = S_C_M3;
            S_C_M3:      n_state = S_C_DIV;
            S_C_DIV:     n_state = alu_rsp.done ? S_DONE : S_C_DIV;
            S_DONE:      n_state = (!r_o_valid || i_m_tready) ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_n          = r_n;
        n_count      = r_count;
        n_sum        = r_sum;
        n_sqsum      = r_sqsum;
        n_min        = r_min;
        n_max        = r_max;
        n_mean       = r_mean;
        n_std        = r_std;
        n_o_valid    = r_o_valid;
        n_alu_busy   = r_alu_busy;
        n_s          = r_s;
        n_w          = r_w;
        n_p          = r_p;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_equal      = r_equal;
        n_prev_val   = r_prev_val;
        n_prev_cum   = r_prev_cum;
        n_sq_tmp     = r_sq_tmp;
        n_t1         = r_t1;
        n_t2         = r_t2;
        n_span       = r_span;
        n_dc         = r_dc;
        n_target     = r_target;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_res_prob   = r_res_prob;
        n_o_data     = r_o_data;
        n_o_status   = r_o_status;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_ra       = r_idx[AW-1:0];
        mem_wa       = r_idx[AW-1:0];
        mem_wv       = r_rd_val;
        mem_wc       = r_rd_cum + CW'(r_w);
        o_s_tready   = (r_state == S_IDLE);
        alu_req.start = alu_state && !r_alu_busy;
        alu_req.op    = ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;

        // output register drains independently
        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_s          = in_s;
                    n_w          = in_w;
                    n_p          = in_p;
                    n_idx        = '0;
                    n_prev_cum   = '0;
                    n_res_status = ST_OK;
                    n_res_val    = '0;
                    n_res_prob   = '0;
                    case (in_kind)
                        K_QUANT: begin
                            if (r_n == '0) begin
                                n_res_status = ST_EMPTY;
                            end else if (in_p > ONE_Q16) begin
                                n_res_status = ST_PROB;
                            end
                        end
                        K_CDF: begin
                            if ((r_n != '0) && (r_count != '0) && (in_s >= r_max)) begin
                                n_res_prob = ONE_Q16;
                            end
                        end
                        K_CLEAR: begin
                            n_n     = '0;
                            n_count = '0;
                            n_sum   = '0;
                            n_sqsum = '0;
                            n_min   = VMAX;
                            n_max   = VMIN;
                            n_mean  = '0;
                            n_std   = '0;
                        end
                        default: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end

            // search for the first entry not below the sample
            S_SCAN_RD: begin
                if (r_idx == r_n) begin
                    n_pos   = r_n;
                    n_equal = 1'b0;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (r_rd_val < r_s) begin
                    n_prev_cum = r_rd_cum;
                    n_idx      = r_idx + NW'(1);
                end else begin
                    n_pos   = r_idx;
                    n_equal = (r_rd_val == r_s);
                end
            end

            // full and saturation checks, then running sums
            S_ADD_CHK: begin
                if (add_full) begin
                    n_res_status = ST_FULL;
                end else if (add_sat) begin
                    n_res_status = ST_SAT;
                end else begin
                    n_count  = r_count + CW'(r_w);
                    n_sum    = r_sum + SW'($signed(sw_prod));
                    n_sq_tmp = (2*VW)'(r_s * r_s);
                    if (r_s > r_max) begin
                        n_max = r_s;
                    end
                    if (r_s < r_min) begin
                        n_min = r_s;
                    end
                    n_idx = r_equal ? n_dec : r_n;
                end
            end

            // move entries up by one adding the weight to their cumulatives, or bump cumulatives in place on a match
            S_MOVE_RD: begin
                if (r_equal || (r_idx != r_pos)) begin
                    mem_re = 1'b1;
                    mem_ra = r_equal ? r_idx[AW-1:0] : idx_dec[AW-1:0];
                end
            end
            S_MOVE_WR: begin
                mem_we = 1'b1;
                if (!(r_equal && (r_idx == r_pos))) begin
                    n_idx = idx_dec;
                end
            end
            S_INS_WR: begin
                mem_we = 1'b1;
                mem_wa = r_pos[AW-1:0];
                mem_wv = r_s;
                mem_wc = r_prev_cum + CW'(r_w);
                n_n    = r_n + NW'(1);
            end

            S_SQ_ACC: begin
                n_sqsum = r_sqsum + SQW'(sq_prod);
                if (r_count <= CW'(1)) begin
                    n_std = '0;
                end
            end

            // n * sum of squares
            S_STD_M1: begin
                alu_req.op = ALU_MUL;
                alu_a      = AXW'(r_sqsum);
                alu_b      = BXW'(r_count);
                if (alu_rsp.done) begin
                    n_t1 = alu_res;
                end
            end
            // sum squared
            S_STD_M2: begin
                alu_req.op = ALU_MUL;
                alu_a      = AXW'(sum_mag);
                alu_b      = BXW'(sum_mag);
                if (alu_rsp.done) begin
                    n_t2 = alu_res;
                end
            end
            S_STD_CMP: begin
                if (r_t1 <= r_t2) begin
                    n_std = '0;
                end else begin
                    n_t1 = r_t1 - r_t2;
                end
            end
            S_STD_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = r_t1;
                alu_b      = BXW'(cnt_pair);
                if (alu_rsp.done) begin
                    n_t1 = AXW'(alu_res[BXW-1:0]);
                end
            end
            S_STD_SQRT: begin
                alu_req.op = ALU_SQRT;
                alu_a      = r_t1;
                if (alu_rsp.done) begin
                    n_std = (alu_res[BXW-1:0] > BXW'(VMASK)) ? VMASK : alu_res[VW-1:0];
                end
            end
            // floored mean from magnitude quotient and remainder
            S_MEAN_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = AXW'(sum_mag);
                alu_b      = BXW'(r_count);
                if (alu_rsp.done) begin
                    if (r_sum[SW-1]) begin
                        n_mean = ~mean_q + VW'(alu_rem == '0);
                    end else begin
                        n_mean = mean_q;
                    end
                end
            end

            // quantile scan over cumulatives
            S_Q_MUL: begin
                n_target = tgt_prod[PW+CW-2:16];
                n_idx    = '0;
            end
            S_Q_RD: begin
                if (r_idx != r_n) begin
                    mem_re = 1'b1;
                end
            end
            S_Q_CMP: begin
                if (r_rd_cum > r_target) begin
                    n_res_val = r_rd_val;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            S_Q_LAST_RD: begin
                mem_re = 1'b1;
                mem_ra = n_dec[AW-1:0];
            end
            S_Q_LAST_CAP: begin
                n_res_val = r_rd_val;
            end

            // cdf: find the bracketing pair, then interpolate
            S_C_RD: begin
                mem_re = 1'b1;
            end
            S_C_CMP: begin
                if (cdf_go_on) begin
                    n_prev_val = r_rd_val;
                    n_prev_cum = r_rd_cum;
                    n_idx      = r_idx + NW'(1);
                end else begin
                    n_span = v1_off;
                    n_dc   = r_rd_cum - r_prev_cum;
                end
            end
            S_C_M1: begin
                n_t1 = AXW'(cm_prod);
            end
            S_C_M2: begin
                n_t1 = r_t1 + AXW'(d_off * r_dc);
            end
            S_C_M3: begin
                n_t2 = AXW'(r_count * r_span);
            end
            S_C_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = {r_t1[AXW-17:0], 16'b0};
                alu_b      = r_t2[BXW-1:0];
                if (alu_rsp.done) begin
                    n_res_prob = alu_res[PW-1:0];
                end
            end

            // load the output register once it is free
            S_DONE: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_data   = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, r_n, r_max, r_min,
                                  r_count, r_std, r_mean, r_res_prob, r_res_val};
                end
            end
            default: begin
                n_o_valid = r_o_valid;
            end
        endcase

        // track the arithmetic unit request
        if (alu_req.start) begin
            n_alu_busy = 1'b1;
        end else if (alu_rsp.done) begin
            n_alu_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_n        <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_sqsum    <= '0;
            r_min      <= VMAX;
            r_max      <= VMIN;
            r_mean     <= '0;
            r_std      <= '0;
            r_o_valid  <= 1'b0;
            r_alu_busy <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_sqsum    <= n_sqsum;
            r_min      <= n_min;
            r_max      <= n_max;
            r_mean     <= n_mean;
            r_std      <= n_std;
            r_o_valid  <= n_o_valid;
            r_alu_busy <= n_alu_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s          <= n_s;
        r_w          <= n_w;
        r_p          <= n_p;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_equal      <= n_equal;
        r_prev_val   <= n_prev_val;
        r_prev_cum   <= n_prev_cum;
        r_sq_tmp     <= n_sq_tmp;
        r_t1         <= n_t1;
        r_t2         <= n_t2;
        r_span       <= n_span;
        r_dc         <= n_dc;
        r_target     <= n_target;
        r_res_status <= n_res_status;
        r_res_val    <= n_res_val;
        r_res_prob   <= n_res_prob;
        r_o_data     <= n_o_data;
        r_o_status   <= n_o_status;
    end

    // sorted table, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_val[mem_wa] <= mem_wv;
            m_cum[mem_wa] <= mem_wc;
        end
        if (mem_re) begin
            r_rd_val <= m_val[mem_ra];
            r_rd_cum <= m_cum[mem_ra];
        end
    end

    wsdt_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_rsp   (alu_rsp),
        .o_res   (alu_res),
        .o_rem   (alu_rem)
    );

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_status;

endmodule
